>>> hw/rtl/fba_pkg.sv
package fba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int BIX_W      = 4;
  localparam int STAT_W     = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] STAT_LOADED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ALLOC   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOALLOC = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  // Search token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic [DATA_W-1:0] amt;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [DATA_W-1:0] best;
  } tok_t;

  // Write command broadcast to every cell; only the addressed cell acts.
  typedef struct packed {
    logic              load;
    logic              sub;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] amt;
  } wr_t;

  // The reported index is the table index kept to its low four bits.
  function automatic logic [BIX_W-1:0] to_bix(input logic [IDX_W-1:0] i);
    logic [IDX_W+BIX_W-1:0] w;
    w = (IDX_W + BIX_W)'(i);
    return w[BIX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/fba_if.sv
interface fba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [fba_pkg::DATA_W-1:0] amount;

  modport source (output valid, output opcode, output amount, input ready);
  modport sink (input valid, input opcode, input amount, output ready);
endinterface

interface fba_res_if;
  logic                       valid;
  logic                       ready;
  logic [fba_pkg::STAT_W-1:0] status;
  logic [fba_pkg::BIX_W-1:0]  block_index;

  modport source (output valid, output status, output block_index, input ready);
  modport sink (input valid, input status, input block_index, output ready);
endinterface

>>> hw/rtl/fba_cell.sv
module fba_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [fba_pkg::IDX_W-1:0] idx,
  input  logic                     loaded,
  input  logic                     fit_mode,
  input  fba_pkg::wr_t             wr,
  input  fba_pkg::tok_t            tok_in,
  output fba_pkg::tok_t            tok_out
);
  import fba_pkg::*;

  logic [DATA_W-1:0] cap;
  logic              fits;
  logic              take;

  assign fits = loaded && (cap >= tok_in.amt);
  // First fit keeps the first hit; best fit replaces only on a strictly smaller room.
  assign take = fits && (!tok_in.found || (fit_mode && (cap < tok_in.best)));

  always_ff @(posedge clk) begin
    if (wr.load && (wr.idx == idx)) begin
      cap <= wr.amt;
    end else if (wr.sub && (wr.idx == idx)) begin
      cap <= cap - wr.amt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.amt <= tok_in.amt;
    if (take) begin
      tok_out.found <= 1'b1;
      tok_out.pick  <= idx;
      tok_out.best  <= cap;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.pick  <= tok_in.pick;
      tok_out.best  <= tok_in.best;
    end
  end

  a_tok_moves: assert property (@(posedge clk) disable iff (rst)
    tok_in.active |=> tok_out.active)
    else $error("search token lost in cell");

  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr.load && wr.sub))
    else $error("load and allocate write in the same cycle");

  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    (tok_in.active && take) |=> (tok_out.found && (tok_out.best >= tok_out.amt)))
    else $error("chosen block does not cover the request");

endmodule

>>> hw/rtl/fit_block_allocator.sv
// Load request: the result is held in the pending register from acceptance and
// enters the output register from the pending state. Allocation request: the
// search token crosses MAX_BLOCKS cells, one per cycle, and its result then takes
// the same path through the pending register. One request is in work at a time;
// the next is taken once the previous result has entered the output register, and
// later while an earlier result still waits in the output register for out_res.ready.
// Reset clears the fill count, fit_mode and control; block capacities are not cleared.
module fit_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  fba_req_if.sink                     in_req,
  fba_res_if.source                   out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fba_pkg::*;

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PEND = 2'd2;

  localparam logic [2:0] ADDR_FIT_MODE = 3'd0;

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic              fit_mode;
  logic [STAT_W-1:0] pend_status;
  logic [BIX_W-1:0]  pend_index;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [BIX_W-1:0]  out_index;

  logic              accept;
  logic              full;
  logic              cfg_wr;
  logic [MAX_BLOCKS-1:0] loaded;
  logic [MAX_BLOCKS-1:0] tok_act;
  tok_t              tok [MAX_BLOCKS+1];
  tok_t              tok_end;
  wr_t               wr;

  // Configuration port: one register, written in the APB access phase. Registers
  // sit on word boundaries, so only the word-select bit of the address is decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_FIT_MODE[2]);
  assign prdata = (paddr[2] == ADDR_FIT_MODE[2]) ? {31'd0, fit_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= 1'b0;
    end else if (cfg_wr) begin
      fit_mode <= pwdata[0];
    end
  end

  // Requests are taken only while no other request is in work. A finished
  // result may still sit in the output register; it parts the two sides.
  assign in_req.ready = (state == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign full         = (count >= CNT_W'(MAX_BLOCKS));

  // An allocation request enters the first cell as a fresh token.
  assign tok[0] = '{active: accept && (in_req.opcode == OP_ALLOC),
                    amt:    in_req.amount,
                    found:  1'b0,
                    pick:   '0,
                    best:   '0};

  assign tok_end = tok[MAX_BLOCKS];

  // Loads write in the idle state, the allocation write-back happens when the
  // token leaves the last cell; the two never meet.
  always_comb begin
    wr.load = accept && (in_req.opcode == OP_LOAD) && !full;
    wr.sub  = (state == S_SCAN) && tok_end.active && tok_end.found;
    if (state == S_SCAN) begin
      wr.idx = tok_end.pick;
      wr.amt = tok_end.amt;
    end else begin
      wr.idx = count[IDX_W-1:0];
      wr.amt = in_req.amount;
    end
  end

  // The row of cells. Cell j holds block j and sees whether it is loaded.
  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    assign loaded[j]  = (CNT_W'(j) < count);
    assign tok_act[j] = tok[j+1].active;

    fba_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(j)),
      .loaded   (loaded[j]),
      .fit_mode (fit_mode),
      .wr       (wr),
      .tok_in   (tok[j]),
      .tok_out  (tok[j+1])
    );
  end

  // Controller: takes a request, waits for the scan when needed, and hands the
  // result to the output register as soon as that register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_req.opcode == OP_LOAD) begin
              if (!full) begin
                count <= count + CNT_W'(1);
              end
              state <= S_PEND;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tok_end.active) begin
            state <= S_PEND;
          end
        end
        S_PEND: begin
          if (!out_valid || out_res.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pending result payload, held until the output register takes it.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept && (in_req.opcode == OP_LOAD)) begin
      if (full) begin
        pend_status <= STAT_FULL;
        pend_index  <= '0;
      end else begin
        pend_status <= STAT_LOADED;
        pend_index  <= to_bix(count[IDX_W-1:0]);
      end
    end else if ((state == S_SCAN) && tok_end.active) begin
      if (tok_end.found) begin
        pend_status <= STAT_ALLOC;
        pend_index  <= to_bix(tok_end.pick);
      end else begin
        pend_status <= STAT_NOALLOC;
        pend_index  <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_PEND) && (!out_valid || out_res.ready)) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PEND) && (!out_valid || out_res.ready)) begin
      out_status <= pend_status;
      out_index  <= pend_index;
    end
  end

  assign out_res.valid       = out_valid;
  assign out_res.status      = out_status;
  assign out_res.block_index = out_index;

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_act))
    else $error("more than one search token in the cell row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    (tok_act != '0) |-> (state == S_SCAN))
    else $error("search token outside of a scan");

  a_sub_loaded: assert property (@(posedge clk) disable iff (rst)
    wr.sub |-> (CNT_W'(wr.idx) < count))
    else $error("allocation write to an unloaded block");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS))
    else $error("fill count beyond table size");

endmodule

>>> dv/fba_alloc_checker.sv
module fba_alloc_checker
  import fba_pkg::*;
#(
  parameter logic [2:0] FIT_MODE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  fba_req_if          req,
  fba_res_if          res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BIX_W-1:0]  block_index;
  } placement_t;

  logic [DATA_W-1:0] free_room [MAX_BLOCKS];
  int                blocks_in_table;
  logic              best_fit;
  placement_t        placement_q[$];

  // Applies one request to the shadow table and returns the placement it should report.
  function automatic placement_t predict_placement(input logic op, input logic [DATA_W-1:0] amt);
    placement_t r;
    logic       found;
    int         pick;
    found = 1'b0;
    pick  = 0;
    if (op == OP_LOAD) begin
      if (blocks_in_table >= MAX_BLOCKS) begin
        r = '{STAT_FULL, '0};
      end else begin
        free_room[blocks_in_table] = amt;
        r = '{STAT_LOADED, BIX_W'(blocks_in_table)};
        blocks_in_table++;
      end
    end else begin
      for (int j = 0; j < blocks_in_table; j++) begin
        if (free_room[j] >= amt) begin
          if (!found) begin
            found = 1'b1;
            pick  = j;
            if (!best_fit) break;
          end else if (free_room[j] < free_room[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        free_room[pick] = free_room[pick] - amt;
        r = '{STAT_ALLOC, BIX_W'(pick)};
      end else begin
        r = '{STAT_NOALLOC, '0};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      blocks_in_table = 0;
      best_fit        = 1'b0;
      placement_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == FIT_MODE_ADDR) begin
        best_fit = pwdata[0];
      end
      if (res.valid && res.ready) begin
        if (placement_q.size() == 0) begin
          $display("%0t: result with nothing expected, got status %0d index %0d",
                   $time, res.status, res.block_index);
          mismatches++;
        end else begin
          want = placement_q.pop_front();
          if (res.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, res.status);
            mismatches++;
          end
          if (res.block_index !== want.block_index) begin
            $display("%0t: block_index mismatch, expected %0d, got %0d",
                     $time, want.block_index, res.block_index);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        placement_q.push_back(predict_placement(req.opcode, req.amount));
      end
    end
    pending <= placement_q.size();
  end

endmodule

>>> dv/fit_block_allocator_tb.sv
module fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fba_pkg::*;

  // The only register, fit_mode, sits at byte address zero.
  localparam logic [2:0] FIT_MODE_ADDR = 3'd0;
  localparam logic       FIRST_FIT     = 1'b0;
  localparam logic       BEST_FIT      = 1'b1;

  localparam int IDLE_PCT      = 22;
  localparam int LOAD_PCT      = 12;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_CYCLES   = 200;
  // Leave some margin after the last result.
  localparam int DRAIN_CYCLES  = MAX_BLOCKS + 8;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fba_req_if req_ch ();
  fba_res_if res_ch ();

  int pending;
  int mismatches;

  // Both sides stop idling while this is set.
  bit no_idle;
  // Asks the result side for one long hold-off.
  bit hold_request;

  // Capacities loaded so far, used to aim request sizes near real blocks.
  logic [DATA_W-1:0] load_history[$];

  fit_block_allocator i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_req  (req_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fba_alloc_checker #(
    .FIT_MODE_ADDR (FIT_MODE_ADDR)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #400us;
    $display("Verification failed");
    $finish;
  end

  // Result side. It owns the ready line alone, so the long hold-off is counted here
  // while the request side keeps offering work and the block backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request, with random idle cycles in front, and returns at the edge
  // where the block takes it. Valid gets at most one assignment per edge.
  task automatic push_request(input logic op, input logic [DATA_W-1:0] amt);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.amount <= amt;
    if (op == OP_LOAD) load_history.push_back(amt);
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge where pready is seen.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stops offering requests and waits until every result is back and the block is quiet.
  // The first edge is always taken, so the count already includes the last request.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the placement policy with random junk in the unused upper bits.
  task automatic set_policy(input logic mode);
    write_reg(FIT_MODE_ADDR, {31'($urandom()), mode});
  endtask

  // Block capacities lean toward small values so that equal capacities, and with
  // them best-fit ties, come up often.
  function automatic logic [DATA_W-1:0] pick_capacity();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(31);
      5, 6:    return $urandom_range(100000);
      default: return $urandom();
    endcase
  endfunction

  // Request sizes cover the extremes, small sizes, sizes tied to loaded capacities,
  // and the full range at every magnitude.
  function automatic logic [DATA_W-1:0] pick_size();
    logic [DATA_W-1:0] base;
    if (load_history.size() == 0) return $urandom();
    base = load_history[$urandom_range(load_history.size() - 1)];
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(15);
      4, 5:    return base >> $urandom_range(6);
      6:       return base + $urandom_range(2) - 1;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    logic op;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_LOAD;
    req_ch.amount <= '0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first fit. Requests against an empty table find nothing.
    set_policy(FIRST_FIT);
    push_request(OP_ALLOC, '0);
    push_request(OP_ALLOC, '1);
    push_request(OP_LOAD, '1);
    push_request(OP_LOAD, '0);
    push_request(OP_LOAD, 32'd5);
    push_request(OP_LOAD, 32'd100);
    push_request(OP_LOAD, 32'd5);
    push_request(OP_LOAD, 32'd50);
    push_request(OP_LOAD, 32'd1);
    // A zero-size request fits the first block and leaves its capacity alone.
    push_request(OP_ALLOC, '0);
    push_request(OP_ALLOC, 32'd6);
    // Too large once the first block has shrunk, then an exact fit that empties it.
    push_request(OP_ALLOC, '1);
    push_request(OP_ALLOC, 32'hFFFF_FFF9);
    push_request(OP_ALLOC, 32'd101);
    drain();

    // Directed part, best fit. Two blocks of five tie and the lower index must win;
    // a zero-size request goes to the smallest block.
    set_policy(BEST_FIT);
    push_request(OP_ALLOC, 32'd5);
    push_request(OP_ALLOC, '0);
    push_request(OP_ALLOC, 32'd50);
    push_request(OP_ALLOC, 32'd1);
    push_request(OP_ALLOC, 32'd5);
    push_request(OP_ALLOC, 32'd95);

    // Random part. Loads are sparse, so the table fills partway through the first
    // phase and later loads exercise the full-table case. Phases alternate the
    // policy; one phase carries the long result hold-off, another runs with no
    // idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      set_policy((phase % 2 == 1) ? BEST_FIT : FIRST_FIT);
      no_idle = (phase == 2);
      if (phase == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < LOAD_PCT) ? OP_LOAD : OP_ALLOC;
        push_request(op, (op == OP_LOAD) ? pick_capacity() : pick_size());
      end
    end
    no_idle = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/fba_pkg.sv
hw/rtl/fba_if.sv
hw/rtl/fba_cell.sv
hw/rtl/fit_block_allocator.sv
dv/fba_alloc_checker.sv
dv/fit_block_allocator_tb.sv
